FILE: hdl/atn_pkg.sv
// Shared types, constants and character helpers for the token normalizer.
package atn_pkg;

  localparam int MAX_CHAR_BYTES = 6;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // character classes
  localparam logic [2:0] CLS_REMOVE = 3'd0;
  localparam logic [2:0] CLS_ALIF   = 3'd1;
  localparam logic [2:0] CLS_MAQSRA = 3'd2;
  localparam logic [2:0] CLS_YEHHMZ = 3'd3;
  localparam logic [2:0] CLS_TEHMRB = 3'd4;
  localparam logic [2:0] CLS_KEEP   = 3'd5;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  // one unit of work handed from front to back: data bytes, then an optional end marker
  typedef struct packed {
    logic [2:0]       n;
    logic [5:0][7:0]  data_bytes;
    logic             has_end;
    logic [15:0]      start_off;
    logic [15:0]      end_off;
    logic [15:0]      len;
  } job_t;

  function automatic logic [30:0] decode_cp(input logic [5:0][7:0] b, input logic [2:0] a);
    logic [7:0]  lead_mask;
    logic [30:0] cp;
    lead_mask = 8'hFF >> ({1'b0, a} + 4'd1);
    cp = {23'd0, b[0] & lead_mask};
    for (int k = 1; k < MAX_CHAR_BYTES; k++) begin
      if (3'(k) < a) begin
        cp = {cp[24:0], b[k][5:0]};
      end
    end
    return cp;
  endfunction

  function automatic logic [2:0] classify(input logic [30:0] cp);
    logic [2:0] c;
    if (cp == 31'd1548 || (cp >= 31'd1552 && cp <= 31'd1562) ||
        (cp >= 31'd1750 && cp <= 31'd1773) || cp == 31'd1600 ||
        (cp >= 31'd1611 && cp <= 31'd1631) || cp == 31'd1648) begin
      c = CLS_REMOVE;
    end else if (cp == 31'd1571 || cp == 31'd1573 || cp == 31'd1570 || cp == 31'd1649) begin
      c = CLS_ALIF;
    end else if (cp == 31'd1610) begin
      c = CLS_MAQSRA;
    end else if (cp == 31'd1569) begin
      c = CLS_YEHHMZ;
    end else if (cp == 31'd1607) begin
      c = CLS_TEHMRB;
    end else begin
      c = CLS_KEEP;
    end
    return c;
  endfunction

endpackage

FILE: hdl/atn_front.sv
// Front end: takes text bytes, tracks word and character state, builds jobs.
module atn_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    text_byte,
  input  logic          final_byte,
  input  logic          q_full,
  output logic          job_push,
  output atn_pkg::job_t job
);
  import atn_pkg::*;

  logic [OFFSET_BITS-1:0] byte_position;
  logic                   in_word;
  logic [OFFSET_BITS-1:0] word_start;
  logic [15:0]            emitted_count;
  logic [5:0][7:0]        pend;
  logic [2:0]             pend_count;
  logic [2:0]             exp_count;

  logic                   accept;
  logic                   is_space;
  logic                   punct;
  logic [5:0][7:0]        cur;
  logic [2:0]             pc_after;
  logic [2:0]             exp_after;
  logic [2:0]             step_n;
  logic [5:0][7:0]        step_bytes;
  logic [2:0]             lead_len;
  logic                   close;
  logic [OFFSET_BITS-1:0] pos_inc;

  function automatic logic is_punct(input logic [7:0] b);
    logic r;
    case (b)
      8'h20, 8'h3F, 8'h2E, 8'h23, 8'h21, 8'h2A, 8'h25, 8'h5E, 8'h7E, 8'h60,
      8'h22, 8'h3E, 8'h3C, 8'h3B, 8'h29, 8'h28, 8'h2B, 8'h2D, 8'h3D, 8'h24,
      8'h2F, 8'h5C, 8'h7C, 8'h2C, 8'h3A, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h5F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign is_space = (text_byte == SPACE_BYTE);
  assign punct    = is_punct(text_byte);
  assign pos_inc  = byte_position + 1'b1;

  always_comb begin
    if (text_byte < 8'hE0)      lead_len = 3'd2;
    else if (text_byte < 8'hF0) lead_len = 3'd3;
    else if (text_byte < 8'hF8) lead_len = 3'd4;
    else if (text_byte < 8'hFC) lead_len = 3'd5;
    else                        lead_len = 3'd6;
  end

  always_comb begin
    cur        = pend;
    pc_after   = pend_count;
    exp_after  = exp_count;
    step_n     = 3'd0;
    step_bytes = '0;
    if (!punct) begin
      if (exp_count != 3'd0) begin
        cur[pend_count] = text_byte;
        pc_after = pend_count + 3'd1;
        if (pc_after >= exp_count) begin
          pc_after  = 3'd0;
          exp_after = 3'd0;
          case (classify(decode_cp(cur, exp_count)))
            CLS_REMOVE: step_n = 3'd0;
            CLS_ALIF: begin
              step_n = 3'd2; step_bytes[0] = 8'hD8; step_bytes[1] = 8'hA7;
            end
            CLS_MAQSRA: begin
              step_n = 3'd2; step_bytes[0] = 8'hD9; step_bytes[1] = 8'h89;
            end
            CLS_YEHHMZ: begin
              step_n = 3'd2; step_bytes[0] = 8'hD8; step_bytes[1] = 8'hA6;
            end
            CLS_TEHMRB: begin
              step_n = 3'd2; step_bytes[0] = 8'hD8; step_bytes[1] = 8'hA9;
            end
            default: begin
              step_n = exp_count; step_bytes = cur;
            end
          endcase
        end
      end else if (text_byte[7:6] == 2'b11 && text_byte < 8'hFE) begin
        cur[0]    = text_byte;
        pc_after  = 3'd1;
        exp_after = lead_len;
      end else begin
        step_n        = 3'd1;
        step_bytes[0] = text_byte;
      end
    end
  end

  // a space closes an open word; the last byte closes whatever word it leaves open
  assign close = is_space ? in_word : final_byte;

  always_comb begin
    job.has_end    = close;
    job.start_off  = 16'(word_start);
    job.end_off    = is_space ? 16'(byte_position) : 16'(pos_inc);
    if (close && pc_after != 3'd0) begin
      // incomplete character flushed as is
      job.n          = pc_after;
      job.data_bytes = cur;
    end else begin
      job.n          = step_n;
      job.data_bytes = step_bytes;
    end
    job.len = emitted_count + 16'(job.n);
  end

  assign job_push = accept && (job.n != 3'd0 || close);

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      in_word       <= 1'b0;
      word_start    <= '0;
      emitted_count <= '0;
      pend_count    <= '0;
      exp_count     <= '0;
    end else if (accept) begin
      if (final_byte) begin
        byte_position <= '0;
        in_word       <= 1'b0;
        word_start    <= '0;
        emitted_count <= '0;
        pend_count    <= '0;
        exp_count     <= '0;
      end else begin
        byte_position <= pos_inc;
        in_word       <= !is_space;
        if (close) begin
          word_start    <= byte_position;
          emitted_count <= '0;
          pend_count    <= '0;
          exp_count     <= '0;
        end else begin
          emitted_count <= job.len;
          pend_count    <= pc_after;
          exp_count     <= exp_after;
        end
      end
    end
  end

endmodule

FILE: hdl/atn_queue.sv
// Short job queue between the front and the back.
module atn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  atn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output atn_pkg::job_t head_job,
  output logic          empty
);
  import atn_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: hdl/atn_back.sv
// Back end: walks one job at a time, one result word per cycle while pop is held.
module atn_back (
  input  logic          clk,
  input  logic          rst,
  input  atn_pkg::job_t head_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic          is_token_end,
  output logic [7:0]    token_byte,
  output logic [15:0]   start_offset,
  output logic [15:0]   end_offset,
  output logic [15:0]   token_length,
  output logic          last_of_run
);
  import atn_pkg::*;

  job_t       job;
  logic       valid;
  logic [2:0] idx;
  logic [2:0] total;
  logic       marker;
  logic       last;
  logic       take;
  logic       load;

  assign total  = job.n + {2'b00, job.has_end};
  assign marker = (idx >= job.n);
  assign last   = (idx == total - 3'd1);
  assign take   = pop && valid;
  assign load   = !q_empty && (!valid || (take && last));
  assign q_pop  = load;

  assign empty        = !valid;
  assign is_token_end = marker;
  assign token_byte   = marker ? 8'd0 : job.data_bytes[idx];
  assign start_offset = marker ? job.start_off : 16'd0;
  assign end_offset   = marker ? job.end_off : 16'd0;
  assign token_length = marker ? job.len : 16'd0;
  assign last_of_run  = last;

  always_ff @(posedge clk) begin
    if (load) begin
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take && last) begin
      valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

FILE: hdl/arabic_text_token_normalizer_top.sv
// Top level of the token normalizer: front, job queue, back.
//
//  channel  dir  handshake       fields
//  input    in   push / full     text_byte, final_byte
//  result   out  empty / pop     is_token_end, token_byte, start_offset,
//                                end_offset, token_length, last_of_run
//
// One byte is taken per cycle while full is low; it yields up to seven result words,
// which the back end hands out one per cycle while pop is held, so the result port
// sets the pace. A four-entry job queue sits between the front and the back end;
// full rises only when it is full. Bytes that give no result are taken but push no job.
// rst is synchronous and clears all control state; no clearing pass is needed.
module arabic_text_token_normalizer_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        empty,
  input  logic        pop,
  output logic        is_token_end,
  output logic [7:0]  token_byte,
  output logic [15:0] start_offset,
  output logic [15:0] end_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);
  import atn_pkg::*;

  job_t front_job;
  job_t head_job;
  logic job_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  atn_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .job_push   (job_push),
    .job        (front_job)
  );

  atn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  atn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .is_token_end (is_token_end),
    .token_byte   (token_byte),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: dv/arabic_text_token_normalizer_top_tb.sv
// Self-checking testbench for the Arabic text token normalizer top level.
module arabic_text_token_normalizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atn_pkg::*;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  tbyte;
    logic [15:0] s_off;
    logic [15:0] e_off;
    logic [15:0] len;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [7:0] tbyte;
    logic       fin;
    logic       pin;
    word_t      pin_word;
  } step_t;

  localparam int RANDOM_ITEMS = 135;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_SHOWN    = 10;

  localparam logic [7:0] PUNCT [30] = '{
    8'h20, 8'h3F, 8'h2E, 8'h23, 8'h21, 8'h2A, 8'h25, 8'h5E, 8'h7E, 8'h60,
    8'h22, 8'h3E, 8'h3C, 8'h3B, 8'h29, 8'h28, 8'h2B, 8'h2D, 8'h3D, 8'h24,
    8'h2F, 8'h5C, 8'h7C, 8'h2C, 8'h3A, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h5F};

  // code points on and around the edges of the removed and folded sets
  localparam int ARABIC_CP [24] = '{
    1548, 1552, 1557, 1562, 1750, 1760, 1773, 1600, 1611, 1620, 1631, 1648,
    1570, 1571, 1573, 1649, 1610, 1569, 1607, 1551, 1563, 1749, 1774, 1547};

  // pinned rows carry their closing word as worked out by hand
  localparam step_t SCRIPT [27] = '{
    '{8'h61, 1'b0, 1'b1, '{1'b0, 8'h61, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{8'hD8, 1'b0, 1'b0, '0},  // hamza-above alif
    '{8'hA3, 1'b0, 1'b0, '0},
    '{8'hD9, 1'b0, 1'b0, '0},  // yeh
    '{8'h8A, 1'b0, 1'b0, '0},
    '{8'hD8, 1'b0, 1'b0, '0},  // hamza
    '{8'hA1, 1'b0, 1'b0, '0},
    '{8'hD9, 1'b0, 1'b0, '0},  // heh
    '{8'h87, 1'b0, 1'b0, '0},
    '{8'hD9, 1'b0, 1'b0, '0},  // fathatan, removed
    '{8'h8B, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},  // stray continuation
    '{8'h20, 1'b0, 1'b1, '{1'b1, 8'h00, 16'd0, 16'd13, 16'd11, 1'b1}},
    '{8'hFC, 1'b0, 1'b0, '0},
    '{8'h21, 1'b0, 1'b0, '0},  // punct while gathering
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h20, 1'b1, 1'b1, '{1'b1, 8'h00, 16'd13, 16'd17, 16'd2, 1'b1}},
    '{8'h20, 1'b0, 1'b0, '0},  // leading space
    '{8'h3F, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b1, '{1'b1, 8'h00, 16'd0, 16'd2, 16'd0, 1'b1}},
    '{8'hFD, 1'b0, 1'b0, '0},  // six-byte char, kept whole
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b1, 1'b1, '{1'b1, 8'h00, 16'd2, 16'd9, 16'd6, 1'b1}}};

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        is_token_end;
  logic [7:0]  token_byte;
  logic [15:0] start_offset;
  logic [15:0] end_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  arabic_text_token_normalizer_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .empty        (empty),
    .pop          (pop),
    .is_token_end (is_token_end),
    .token_byte   (token_byte),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("FAIL arabic_text_token_normalizer_top");
    $finish;
  end

  // normalizer state mirrored for prediction
  logic [15:0] text_pos;
  logic [15:0] token_start;
  logic [15:0] token_len;
  bit          inside_token;
  logic [7:0]  char_buf [6];
  int          char_have;
  int          char_need;

  word_t       due_words [$];
  logic [7:0]  text_q [$];
  int          mismatches;
  int          words_seen;
  bit          quiet_run;

  function automatic int draw_gap();
    return quiet_run ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic bit is_punct(input logic [7:0] b);
    foreach (PUNCT[i]) if (PUNCT[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_state();
    text_pos     = '0;
    token_start  = '0;
    token_len    = '0;
    inside_token = 1'b0;
    char_have    = 0;
    char_need    = 0;
    foreach (char_buf[i]) char_buf[i] = '0;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    due_words.push_back('{1'b0, b, 16'd0, 16'd0, 16'd0, 1'b0});
    token_len++;
  endfunction

  function automatic logic [2:0] fold_class(input logic [31:0] cp);
    if (cp inside {1548, [1552:1562], [1750:1773], 1600, [1611:1631], 1648})
      return CLS_REMOVE;
    if (cp inside {1571, 1573, 1570, 1649}) return CLS_ALIF;
    if (cp == 1610) return CLS_MAQSRA;
    if (cp == 1569) return CLS_YEHHMZ;
    if (cp == 1607) return CLS_TEHMRB;
    return CLS_KEEP;
  endfunction

  function automatic void finish_char();
    logic [31:0] cp;
    cp = {24'd0, char_buf[0] & (8'hFF >> (char_need + 1))};
    for (int k = 1; k < char_need; k++) cp = (cp << 6) | char_buf[k][5:0];
    case (fold_class(cp))
      CLS_REMOVE: ;
      CLS_ALIF:   begin emit_byte(8'hD8); emit_byte(8'hA7); end
      CLS_MAQSRA: begin emit_byte(8'hD9); emit_byte(8'h89); end
      CLS_YEHHMZ: begin emit_byte(8'hD8); emit_byte(8'hA6); end
      CLS_TEHMRB: begin emit_byte(8'hD8); emit_byte(8'hA9); end
      default: for (int k = 0; k < char_need; k++) emit_byte(char_buf[k]);
    endcase
    char_have = 0;
    char_need = 0;
  endfunction

  function automatic void close_token(input logic [15:0] stop);
    for (int k = 0; k < char_have && k < 6; k++) emit_byte(char_buf[k]);
    char_have = 0;
    char_need = 0;
    due_words.push_back('{1'b1, 8'h00, token_start, stop, token_len, 1'b0});
    token_len    = '0;
    inside_token = 1'b0;
  endfunction

  // expected words caused by one accepted byte
  function automatic void normalize_byte(input logic [7:0] b, input logic fin);
    int    before_n;
    word_t w;
    before_n = due_words.size();
    if (b == SPACE_BYTE) begin
      if (inside_token) begin
        close_token(text_pos);
        token_start = text_pos;
      end
    end else begin
      inside_token = 1'b1;
      if (is_punct(b)) begin
      end else if (char_need != 0) begin
        if (char_have < 6) char_buf[char_have] = b;
        char_have++;
        if (char_have >= char_need) finish_char();
      end else if (b[7:6] == 2'b11 && b < 8'hFE) begin
        char_buf[0] = b;
        char_have   = 1;
        char_need   = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : (b < 8'hF8) ? 4 :
                      (b < 8'hFC) ? 5 : 6;
      end else begin
        emit_byte(b);
      end
    end
    text_pos++;
    if (fin) begin
      if (inside_token) close_token(text_pos);
      clear_state();
    end
    if (due_words.size() > before_n) begin
      w = due_words.pop_back();
      w.last = 1'b1;
      due_words.push_back(w);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    normalize_byte(b, fin);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  function automatic void add_multi(input int nbytes, input int keep);
    case (nbytes)
      3:       text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      4:       text_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
      5:       text_q.push_back(8'hF8 | 8'($urandom_range(0, 3)));
      default: text_q.push_back(8'hFC | 8'($urandom_range(0, 1)));
    endcase
    for (int k = 1; k < keep; k++) begin
      if ($urandom_range(0, 7) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
  endfunction

  function automatic void add_word();
    int          r;
    int          n;
    logic [10:0] cp;
    for (int c = $urandom_range(1, 6); c > 0; c--) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        cp = $urandom_range(0, 1) ? 11'(ARABIC_CP[$urandom_range(0, 23)]) :
                                    11'($urandom_range(1536, 1791));
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end else if (r < 50) begin
        text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else if (r < 58) begin
        text_q.push_back(PUNCT[$urandom_range(1, 29)]);
      end else if (r < 66) begin
        add_multi(3, 3);
      end else if (r < 72) begin
        n = $urandom_range(4, 6);
        add_multi(n, n);
      end else if (r < 80) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        text_q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(8'hFE, 8'hFF))
                                                  : 8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        // two-byte char split by punctuation
        text_q.push_back(8'hD8 | 8'($urandom_range(0, 1)));
        text_q.push_back(PUNCT[$urandom_range(1, 29)]);
        text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
    end
    // word cut short inside a multibyte char
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(2, 6);
      if (n == 2) text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      else add_multi(n, $urandom_range(1, n - 1));
    end
  endfunction

  task automatic send_text();
    text_q.delete();
    if ($urandom_range(0, 3) == 0) text_q.push_back(SPACE_BYTE);
    for (int w = $urandom_range(1, 5); w > 0; w--) begin
      add_word();
      if (w > 1) repeat ($urandom_range(1, 2)) text_q.push_back(SPACE_BYTE);
    end
    if ($urandom_range(0, 5) == 0) text_q.push_back(SPACE_BYTE);
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic flag_mismatch(input string what, input word_t want, input word_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t: %s exp end=%0d byte=%h start=%0d stop=%0d len=%0d last=%0d",
               $realtime, what, want.is_end, want.tbyte, want.s_off, want.e_off,
               want.len, want.last);
      $display("%0t: %s got end=%0d byte=%h start=%0d stop=%0d len=%0d last=%0d",
               $realtime, what, got.is_end, got.tbyte, got.s_off, got.e_off,
               got.len, got.last);
    end
  endtask

  // result side: random pops, one long hold-off to back the block up
  initial begin : drain
    int    gap;
    word_t got;
    word_t want;
    while (rst) @(posedge clk);
    forever begin
      gap = (words_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = '{is_token_end, token_byte, start_offset, end_offset, token_length, last_of_run};
      words_seen++;
      if (due_words.size() == 0) begin
        flag_mismatch("unexpected word", '0, got);
      end else begin
        want = due_words.pop_front();
        if (got.is_end !== want.is_end || got.tbyte !== want.tbyte ||
            got.s_off !== want.s_off || got.e_off !== want.e_off ||
            got.len !== want.len || got.last !== want.last)
          flag_mismatch("word mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    int    random_items;
    bit    paused;
    word_t w;
    clear_state();
    mismatches   = 0;
    words_seen   = 0;
    quiet_run    = 1'b0;
    random_items = 0;
    paused       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      send_byte(SCRIPT[i].tbyte, SCRIPT[i].fin);
      if (SCRIPT[i].pin) begin
        w = due_words.pop_back();
        due_words.push_back(SCRIPT[i].pin_word);
      end
    end
    wait_drained();

    while (random_items < RANDOM_ITEMS) begin
      quiet_run = ($urandom_range(0, 5) == 0);
      send_text();
      random_items += text_q.size();
      if (!paused && random_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    quiet_run = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("PASS arabic_text_token_normalizer_top");
    end else begin
      $display("FAIL arabic_text_token_normalizer_top");
    end
    $finish;
  end

endmodule
